/* rtl/dtg_pkg.sv */
// Shared types, register map and fixed-point constants of the dual-tone envelope generator.
package dtg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Shared multiplier: 32-bit by 17-bit operands, full product
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [16:0] ENV_ONE   = 17'd65536;
  localparam logic [15:0] OUT_SCALE = 16'd32760;
  localparam logic [16:0] POLY_A    = 17'd102944;
  localparam logic [16:0] POLY_B    = 17'd42047;
  localparam logic [16:0] POLY_C    = 17'd4640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP_FIRST  = 3'd0,
    REG_PHASE_STEP_SECOND = 3'd1,
    REG_VOLUME            = 3'd2,
    REG_TONE_LENGTH       = 3'd3,
    REG_ATTACK_END        = 3'd4,
    REG_DECAY_START       = 3'd5,
    REG_ATTACK_STEP       = 3'd6,
    REG_DECAY_STEP        = 3'd7
  } dtg_reg_t;

  typedef struct packed {
    logic [31:0] phase_step_first;
    logic [31:0] phase_step_second;
    logic [15:0] volume;
    logic [15:0] tone_length;
    logic [15:0] attack_end;
    logic [15:0] decay_start;
    logic [16:0] attack_step;
    logic [16:0] decay_step;
  } dtg_cfg_t;

  localparam dtg_cfg_t CFG_RESET = '{
    phase_step_first:  32'd78741067,
    phase_step_second: 32'd78741067,
    volume:            16'd10486,
    tone_length:       16'd5120,
    attack_end:        16'd410,
    decay_start:       16'd1792,
    attack_step:       17'd160,
    decay_step:        17'd20
  };

  // Multiplier operation issued by the controller
  typedef enum logic [3:0] {
    STEP_NONE  = 4'd0,
    STEP_ENV   = 4'd1,
    STEP_SQ    = 4'd2,
    STEP_U2C   = 4'd3,
    STEP_U2T   = 4'd4,
    STEP_UT    = 4'd5,
    STEP_MAG   = 4'd6,
    STEP_VOL   = 4'd7,
    STEP_SCALE = 4'd8
  } dtg_step_t;

  typedef struct packed {
    logic      accept;
    logic      finish;
    logic      second;
    dtg_step_t step;
  } dtg_cmd_t;

  typedef struct packed {
    logic run_next;
    logic out_free;
  } dtg_status_t;

endpackage

/* rtl/dtg_cfg.sv */
// Configuration register file of the dual-tone envelope generator.
module dtg_cfg import dtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output dtg_cfg_t              cfg
);

  dtg_cfg_t cfg_r;
  dtg_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dtg_reg_t'(cfg_index))
        REG_PHASE_STEP_FIRST:  cfg_nxt.phase_step_first  = cfg_wdata;
        REG_PHASE_STEP_SECOND: cfg_nxt.phase_step_second = cfg_wdata;
        REG_VOLUME:            cfg_nxt.volume            = cfg_wdata[15:0];
        REG_TONE_LENGTH:       cfg_nxt.tone_length       = cfg_wdata[15:0];
        REG_ATTACK_END:        cfg_nxt.attack_end        = cfg_wdata[15:0];
        REG_DECAY_START:       cfg_nxt.decay_start       = cfg_wdata[15:0];
        REG_ATTACK_STEP:       cfg_nxt.attack_step       = cfg_wdata[16:0];
        REG_DECAY_STEP:        cfg_nxt.decay_step        = cfg_wdata[16:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/dtg_ctrl.sv */
// Sequencing state machine: issues one multiplier operation per cycle to the datapath while a sample is computed.
module dtg_ctrl import dtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  dtg_status_t status,
  output dtg_cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_ENV  = 10'b00_0000_0010,
    ST_SA   = 10'b00_0000_0100,
    ST_SB   = 10'b00_0000_1000,
    ST_SC   = 10'b00_0001_0000,
    ST_SD   = 10'b00_0010_0000,
    ST_MAG  = 10'b00_0100_0000,
    ST_VOL  = 10'b00_1000_0000,
    ST_SCL  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } dtg_state_t;

  dtg_state_t state_r;
  dtg_state_t state_nxt;
  logic       second_r;
  logic       second_nxt;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.step   = STEP_NONE;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // skip the arithmetic when no tone is playing
          state_nxt = status.run_next ? ST_ENV : ST_FIN;
        end
      end
      ST_ENV: begin
        cmd.step   = STEP_ENV;
        second_nxt = 1'b0;
        state_nxt  = ST_SA;
      end
      ST_SA: begin
        cmd.step   = STEP_SQ;
        cmd.second = second_r;
        state_nxt  = ST_SB;
      end
      ST_SB: begin
        cmd.step  = STEP_U2C;
        state_nxt = ST_SC;
      end
      ST_SC: begin
        cmd.step  = STEP_U2T;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        cmd.step = STEP_UT;
        if (second_r) begin
          state_nxt = ST_MAG;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = ST_SA;
        end
      end
      ST_MAG: begin
        cmd.step  = STEP_MAG;
        state_nxt = ST_VOL;
      end
      ST_VOL: begin
        cmd.step  = STEP_VOL;
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        cmd.step  = STEP_SCALE;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the sample
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* rtl/dtg_dp.sv */
// Datapath: tone state, shared multiplier, sine polynomial, envelope and output register.
module dtg_dp import dtg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned INDEX_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dtg_cfg_t           cfg,
  input  dtg_cmd_t           cmd,
  output dtg_status_t        status,
  input  logic               in_restart,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_sample_value,
  output logic               out_active,
  output logic               out_last
);

  localparam int unsigned QB  = SINE_TABLE_BITS - 2;
  localparam int unsigned USH = 16 - QB;
  localparam int unsigned CW  = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 1;

  // tone state
  logic [INDEX_BITS-1:0] idx_r;
  logic [31:0]           phase1_r;
  logic [31:0]           phase2_r;
  logic                  running_r;

  // arithmetic registers
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [16:0]        u_r;
  logic [16:0]        u2_r;
  logic               sneg_r;
  logic signed [16:0] sin1_r;
  logic [16:0]        env_r;
  logic               neg_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] sample_r;
  logic               active_r;
  logic               last_r;

  logic [31:0]        phase_sel;
  logic [QB-1:0]      pfrac;
  logic [QB:0]        pos;
  logic [16:0]        u_c;
  logic [16:0]        r_c;
  logic [17:0]        rh_c;
  logic [14:0]        v_c;
  logic signed [16:0] sine_c;
  logic [16:0]        t1_c;
  logic [16:0]        t2_c;
  logic [15:0]        len_c;
  logic [CW-1:0]      i_ext;
  logic [CW-1:0]      len_ext;
  logic               attack_c;
  logic               decay_c;
  logic               last_c;
  logic [15:0]        rem_c;
  logic [16:0]        env_cap;
  logic [16:0]        env_c;
  logic signed [17:0] sum_c;
  logic signed [17:0] sum_neg;
  logic [16:0]        mag_c;
  logic [15:0]        res_c;
  logic signed [15:0] sample_c;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // quarter-wave position of the selected phase
  assign phase_sel = cmd.second ? phase2_r : phase1_r;
  assign pfrac     = phase_sel[29 -: QB];
  assign pos       = phase_sel[30] ? ({1'b1, {QB{1'b0}}} - {1'b0, pfrac}) : {1'b0, pfrac};
  assign u_c       = 17'(pos) << USH;

  // finish the polynomial: round to Q1.15, saturate, apply half-wave sign
  assign r_c    = prod_r[32:16];
  assign rh_c   = ({1'b0, r_c} + 18'd1) >> 1;
  assign v_c    = (rh_c > 18'd32767) ? 15'h7fff : rh_c[14:0];
  assign sine_c = sneg_r ? -$signed({2'b00, v_c}) : $signed({2'b00, v_c});

  assign t1_c = POLY_B - prod_r[32:16];
  assign t2_c = POLY_A - prod_r[32:16];

  // envelope region and end-of-tone detection
  assign len_c    = (cfg.tone_length == '0) ? 16'd1 : cfg.tone_length;
  assign i_ext    = CW'(idx_r);
  assign len_ext  = CW'(len_c);
  assign attack_c = i_ext < CW'(cfg.attack_end);
  assign decay_c  = i_ext > CW'(cfg.decay_start);
  assign rem_c    = (i_ext < len_ext) ? 16'(len_ext - i_ext) : 16'd0;
  assign last_c   = ((i_ext + CW'(1)) >= len_ext) || (idx_r == '1);

  assign env_cap = (prod_r > PROD_W'(ENV_ONE)) ? ENV_ONE : prod_r[16:0];
  assign env_c   = (attack_c || decay_c) ? env_cap : ENV_ONE;

  assign sum_c   = $signed({sin1_r[16], sin1_r}) + $signed({sine_c[16], sine_c});
  assign sum_neg = -sum_c;
  assign mag_c   = sum_c[17] ? sum_neg[16:0] : sum_c[16:0];

  assign res_c    = (prod_r[48:32] > 17'(OUT_SCALE)) ? OUT_SCALE : prod_r[47:32];
  assign sample_c = neg_r ? -$signed(res_c) : $signed(res_c);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_ENV: begin
        if (attack_c) begin
          mul_a = MUL_A_W'(idx_r);
          mul_b = cfg.attack_step;
        end else begin
          mul_a = MUL_A_W'(rem_c);
          mul_b = cfg.decay_step;
        end
      end
      STEP_SQ: begin
        mul_a = MUL_A_W'(u_c);
        mul_b = u_c;
      end
      STEP_U2C: begin
        mul_a = MUL_A_W'(prod_r[32:16]);
        mul_b = POLY_C;
      end
      STEP_U2T: begin
        mul_a = MUL_A_W'(u2_r);
        mul_b = t1_c;
      end
      STEP_UT: begin
        mul_a = MUL_A_W'(u_r);
        mul_b = t2_c;
      end
      STEP_MAG: begin
        mul_a = MUL_A_W'(mag_c);
        mul_b = env_r;
      end
      STEP_VOL: begin
        mul_a = prod_r[31:0];
        mul_b = MUL_B_W'(cfg.volume);
      end
      STEP_SCALE: begin
        mul_a = prod_r[47:16];
        mul_b = MUL_B_W'(OUT_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (cmd.step != STEP_NONE) begin
      prod_r <= prod_nxt;
    end
    if (cmd.step == STEP_SQ) begin
      u_r    <= u_c;
      sneg_r <= phase_sel[31];
      // the first sine finishes as the second starts; the envelope finishes before
      if (cmd.second) begin
        sin1_r <= sine_c;
      end else begin
        env_r <= env_c;
      end
    end
    if (cmd.step == STEP_U2C) begin
      u2_r <= prod_r[32:16];
    end
    if (cmd.step == STEP_MAG) begin
      neg_r <= sum_c[17];
    end
    if (cmd.finish) begin
      sample_r <= running_r ? sample_c : 16'sd0;
      active_r <= running_r;
      last_r   <= running_r && last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      phase1_r    <= '0;
      phase2_r    <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_restart) begin
        idx_r     <= '0;
        phase1_r  <= '0;
        phase2_r  <= '0;
        running_r <= 1'b1;
      end else if (cmd.finish && running_r) begin
        idx_r     <= idx_r + INDEX_BITS'(1);
        phase1_r  <= phase1_r + cfg.phase_step_first;
        phase2_r  <= phase2_r + cfg.phase_step_second;
        running_r <= !last_c;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // run_next in the upper bit, out_free in the lower
  assign status = {in_restart || running_r, !out_valid_r || out_ready};

  assign out_valid        = out_valid_r;
  assign out_sample_value = sample_r;
  assign out_active       = active_r;
  assign out_last         = last_r;

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sample_r <= 16'sd32760) && (sample_r >= -16'sd32760))
    else $error("sample outside output scale");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !active_r |-> (sample_r == 16'sd0) && !last_r)
    else $error("idle sample not silent");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && running_r && last_c |=> !running_r)
    else $error("tone still running after last sample");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_restart |=> running_r && (idx_r == '0) && (phase1_r == '0))
    else $error("restart did not clear tone state");

  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == STEP_MAG |-> env_r <= ENV_ONE)
    else $error("envelope above unity");

endmodule

/* rtl/dual_tone_envelope_generator.sv */
// Dual-tone generator with attack/decay envelope: one signed 16-bit sample per request.
//
// Input channel (in_valid/in_ready, in_restart): every accepted request yields exactly one
// result. in_restart=1 starts a new tone at sample zero with both phases cleared.
// Result channel (out_valid/out_ready): out_sample_value, out_active (a tone sample was
// produced) and out_last (final sample of the tone). Without a tone playing the result is
// all zero.
// Configuration: cfg_we writes cfg_wdata to register cfg_index; write only
// while no request is in flight.
// Computation: a request during a tone runs through the single 32x17 multiplier, which
// serves twelve products per sample: the envelope ramp, four per sine polynomial,
// envelope, volume and output scale. A request with no tone playing skips the arithmetic.
// A new request is taken only once the previous result is in the output register.
// A finished sample waits in the output register; the next request is accepted and
// computed meanwhile, and only its final load waits for out_ready.
// Reset (synchronous, rst_n low) restores the register defaults, clears the tone state
// and drops out_valid.
module dual_tone_envelope_generator import dtg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned INDEX_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample_value,
  output logic                  out_active,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dtg_cfg_t    cfg;
  dtg_cmd_t    cmd;
  dtg_status_t status;

  dtg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dtg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dtg_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_restart       (in_restart),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value),
    .out_active       (out_active),
    .out_last         (out_last)
  );

endmodule
